// ===== rtl/b32e_pkg.sv =====
`timescale 1ns / 1ps

package b32e_pkg;

  // Configuration port geometry and register map.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_PAD_CHAR = 1'b0;
  localparam logic [7:0] PAD_CHAR_RESET = 8'd56;

  // Command queue between the front and the back.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_AW = 2;
  localparam int unsigned CMD_CW = 3;

  // Most characters one byte can produce (data, flush and padding together).
  localparam logic [3:0] MAX_CHARS = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       final_char;
  } out_item_t;

  // One classified byte: up to three 5-bit symbols, then padding.
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic [4:0] sym2;
    logic [1:0] nsym;
    logic [3:0] ntot;
    logic       last;
  } cmd_t;

  // Maps a 5-bit symbol onto the RFC 4648 alphabet A-Z, 2-7.
  function automatic logic [7:0] b32_char(input logic [4:0] s);
    logic [7:0] c;
    if (s < 5'd26) begin
      c = 8'h41 + {3'b000, s};
    end else begin
      c = 8'h32 + {3'b000, s} - 8'd26;
    end
    return c;
  endfunction

endpackage

// ===== rtl/b32e_front.sv =====
`timescale 1ns / 1ps

module b32e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  b32e_pkg::in_item_t in_item,
  output b32e_pkg::cmd_t     cmd
);
  import b32e_pkg::*;

  logic [3:0]  lb_r, lb_nxt;
  logic [2:0]  lc_r, lc_nxt;
  logic [2:0]  pos_r, pos_nxt;

  logic [2:0]  cnt_c;
  logic [3:0]  cnt;
  logic [11:0] res;
  logic        two;
  logic [3:0]  sh0, sh1;
  logic [4:0]  sym0, sym1, flush;
  logic [2:0]  rem;
  logic [3:0]  mask4, low;
  logic        last, has_flush;
  logic [1:0]  nsym;
  logic [2:0]  pos_after, pad;
  logic [3:0]  tot;

  always_comb begin
    cnt_c     = (lc_r > 3'd4) ? 3'd4 : lc_r;
    cnt       = {1'b0, cnt_c} + 4'd8;
    res       = {lb_r, in_item.data_byte};
    last      = in_item.end_of_message;
    two       = (cnt >= 4'd10);
    sh0       = cnt - 4'd5;
    sh1       = cnt - 4'd10;
    sym0      = 5'(res >> sh0);
    sym1      = 5'(res >> sh1);
    rem       = two ? 3'(sh1) : 3'(sh0);
    mask4     = 4'((5'd1 << rem) - 5'd1);
    low       = res[3:0] & mask4;
    // Leftover bits move to the top of the flush symbol, zero-filled below.
    flush     = 5'({1'b0, low} << (3'd5 - rem));
    has_flush = last && (rem != 3'd0);
    nsym      = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
    pos_after = pos_r + {1'b0, nsym};
    pad       = last ? 3'(3'd0 - pos_after) : 3'd0;
    tot       = {2'b00, nsym} + {1'b0, pad};
    if (tot > MAX_CHARS) begin
      tot = MAX_CHARS;
    end

    cmd.sym0 = sym0;
    cmd.sym1 = two ? sym1 : flush;
    cmd.sym2 = flush;
    cmd.nsym = nsym;
    cmd.ntot = tot;
    cmd.last = last;

    lb_nxt  = lb_r;
    lc_nxt  = lc_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (last) begin
        lb_nxt  = 4'd0;
        lc_nxt  = 3'd0;
        pos_nxt = 3'd0;
      end else begin
        lb_nxt  = low;
        lc_nxt  = rem;
        pos_nxt = pos_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r  <= 4'd0;
      lc_r  <= 3'd0;
      pos_r <= 3'd0;
    end else begin
      lb_r  <= lb_nxt;
      lc_r  <= lc_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/b32e_fifo.sv =====
`timescale 1ns / 1ps

module b32e_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b32e_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output b32e_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);
  import b32e_pkg::*;

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wp_r, wp_nxt;
  logic [CMD_AW-1:0] rp_r, rp_nxt;
  logic [CMD_CW-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    do_wr   = wr_en && !full;
    do_rd   = rd_en && !empty;
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CMD_CW'(do_wr) - CMD_CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/b32e_back.sv =====
`timescale 1ns / 1ps

module b32e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b32e_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [7:0]         pad_char,
  input  logic               out_take,
  output logic               out_valid,
  output b32e_pkg::out_item_t out_item
);
  import b32e_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  out_r;
  logic       load, is_end;
  logic [4:0] sym;
  logic [7:0] ch;

  always_comb begin
    load   = cmd_valid && (!ov_r || out_take);
    is_end = (({1'b0, idx_r} + 4'd1) == cmd.ntot);
    case (idx_r)
      3'd0:    sym = cmd.sym0;
      3'd1:    sym = cmd.sym1;
      default: sym = cmd.sym2;
    endcase
    ch = ({1'b0, idx_r} < {2'b00, cmd.nsym}) ? b32_char(sym) : pad_char;

    cmd_pop = load && is_end;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = is_end ? 3'd0 : idx_r + 3'd1;
    end
    ov_nxt = load ? 1'b1 : (out_take ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_char   <= ch;
      out_r.final_char <= cmd.last && is_end;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/base32_stream_encoder.sv =====
`timescale 1ns / 1ps

// Streaming base32 encoder (RFC 4648 alphabet). Bytes are pushed one per item
// with an end_of_message flag; characters come out one per item, and the last
// character of each message carries final_char. Leftover bits are flushed on
// the last byte and the message is padded with the pad character (register 0,
// byte address 0, reset value '8') to a multiple of eight characters. Input can
// be pushed every clock while the four-entry command queue has room; the back
// end emits one character per clock while the reader pops, so a byte yields
// one or two characters (about 1.6 on average) and the last byte of a message
// up to eight, all through the single character output port. A byte's command
// is queued, then its first character is registered at the output.
// Write pad_char only while the encoder is idle.

module base32_stream_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // Byte input queue side.
  input  logic                             push,
  output logic                             full,
  input  b32e_pkg::in_item_t               in_data,
  // Character output queue side.
  input  logic                             pop,
  output logic                             empty,
  output b32e_pkg::out_item_t              out_data,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [b32e_pkg::PADDR_W-1:0]     paddr,
  input  logic [b32e_pkg::PDATA_W-1:0]     pwdata,
  output logic [b32e_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import b32e_pkg::*;

  logic       in_accept;
  cmd_t       front_cmd, q_cmd;
  logic       q_full, q_empty, q_pop;
  logic       out_valid;
  logic [7:0] pad_char_r, pad_char_nxt;
  logic       cfg_wr;

  // An item enters the front as soon as the command queue has room.
  assign in_accept = push && !full;
  assign full      = q_full;

  b32e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_item (in_data),
    .cmd     (front_cmd)
  );

  // The queue decouples byte classification from character emission.
  b32e_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  b32e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_pop),
    .pad_char  (pad_char_r),
    .out_take  (pop && out_valid),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  assign empty = !out_valid;

  // The register index is the word address; only index zero exists.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    pad_char_nxt = pad_char_r;
    if (cfg_wr && (paddr[2] == REG_PAD_CHAR)) begin
      pad_char_nxt = pwdata[7:0];
    end
    prdata = '0;
    if (paddr[2] == REG_PAD_CHAR) begin
      prdata = {{(PDATA_W-8){1'b0}}, pad_char_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_char_r <= PAD_CHAR_RESET;
    end else begin
      pad_char_r <= pad_char_nxt;
    end
  end

endmodule

// ===== rtl/b32e_checker.sv =====
`timescale 1ns / 1ps

module b32e_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input b32e_pkg::out_item_t out_data
);
  import b32e_pkg::*;

  logic [2:0] chars_r, chars_nxt;

  // Counts delivered characters within the current message, modulo eight.
  always_comb begin
    chars_nxt = chars_r;
    if (pop && !empty) begin
      chars_nxt = out_data.final_char ? 3'd0 : chars_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r <= 3'd0;
    end else begin
      chars_r <= chars_nxt;
    end
  end

  // Reset leaves no character waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("output not empty after reset");

  // A waiting character stays until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting character changed or vanished");

  // A full command queue always has a character ready at the output.
  a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue full while output is empty");

  // Every encoded message is a whole number of eight-character blocks.
  a_block_len: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_data.final_char) |-> (chars_r == 3'd7))
    else $error("message length is not a multiple of eight");

endmodule

bind base32_stream_encoder b32e_checker u_b32e_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .pop      (pop),
  .empty    (empty),
  .out_data (out_data)
);
